// File: hdl/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// tlnef_pkg: shared types and constants of the line number / escape filter
// Holds the item structs, the configuration register group, the job record
// passed from the classifier to the emitter, and the character codes.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    // Default count of decimal digits in a line number.
    localparam int DEF_NUMBER_DIGITS = 6;
    // Depth of the job queue between classifier and emitter.
    localparam int JOB_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [2:0] CFG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [2:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [2:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [2:0] CFG_SHOW_NONPRINTING = 3'd4;

    // Numbering modes.
    localparam logic [1:0] NUM_OFF = 2'd0;
    localparam logic [1:0] NUM_ALL = 2'd1;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_QUEST  = 8'd63;
    localparam logic [7:0] CH_UPPER_I = 8'd73;
    localparam logic [7:0] CH_UPPER_M = 8'd77;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_META_LO = 8'd128;
    localparam logic [7:0] CH_META_HI = 8'd159;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    // One classified input byte: whether a line number leads it, and the one
    // to four bytes that follow (tail_last is the index of the final one).
    typedef struct packed {
        logic            has_num;
        logic [1:0]      tail_last;
        logic [3:0][7:0] tail;
    } t_job_ctl;

endpackage

// File: hdl/text_line_number_escape_filter.sv
// ----------------------------------------------------------------------------
// text_line_number_escape_filter: cat-style line numbering and escape filter
// Takes one text byte per item and emits its filtered form, one byte per
// result item, through queue-style handshakes on both sides.
// ----------------------------------------------------------------------------
// Each input byte yields between zero and NUMBER_DIGITS+5 result items: an
// optional right-aligned line number with a tab, then one to four bytes for
// the character itself. The result side delivers one byte per clock cycle
// while results are popped; a plain text byte yields one result item, and a
// squeezed blank line costs nothing on the output side. The byte emitter is
// what sets this rate. A classifier at the input updates the line state and
// counter and hands a job record through a two-entry queue to the emitter,
// so the input keeps accepting items while results wait in the output
// register, until the queue is full. Configuration is for the user to write
// through a simple write port only while the block is idle, which the block
// does not enforce; writes to indexes beyond the five registers are ignored.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [1:0] i_cfg_wdata,
    // Input item side.
    input  logic       push,
    output logic       full,
    input  t_in        i_in,
    // Result item side.
    output logic       empty,
    input  logic       pop,
    output t_out       o_out
);

    localparam int DW    = 4 * NUMBER_DIGITS;
    localparam int CTL_W = $bits(t_job_ctl);
    localparam int JW    = DW + CTL_W;

    t_cfg          r_cfg;

    logic          front_wr;
    logic [DW-1:0] front_digits;
    t_job_ctl      front_ctl;

    logic [JW-1:0] q_wdata, q_rdata;
    logic          q_full, q_empty;

    logic          job_done;
    logic [DW-1:0] back_digits;
    t_job_ctl      back_ctl;

    // Configuration registers; values are masked to their field widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_wdata;
                CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_wdata[0];
                CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_wdata[0];
                CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_wdata[0];
                CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The input is stalled only when the job queue is full.
    assign full = q_full;

    tlnef_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_in         (i_in),
        .i_queue_full (q_full),
        .o_wr         (front_wr),
        .o_digits     (front_digits),
        .o_ctl        (front_ctl)
    );

    assign q_wdata = {front_digits, front_ctl};

    tlnef_fifo #(
        .WIDTH(JW),
        .DEPTH(JOB_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_wdata (q_wdata),
        .i_rd    (job_done),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign back_digits = q_rdata[JW-1 -: DW];
    assign back_ctl    = t_job_ctl'(q_rdata[CTL_W-1:0]);

    tlnef_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_digits    (back_digits),
        .i_ctl       (back_ctl),
        .o_job_done  (job_done),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

// File: hdl/tlnef_fifo.sv
// ----------------------------------------------------------------------------
// tlnef_fifo: small register queue
// First-in first-out queue built from flip-flops; the head is visible
// combinationally while not empty. Push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module tlnef_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: hdl/tlnef_front.sv
// ----------------------------------------------------------------------------
// tlnef_front: input classifier
// Accepts input items, tracks line start, blank-line squeezing and the BCD
// line counter, and turns each surviving byte into one job record.
// ----------------------------------------------------------------------------
module tlnef_front
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_push,
    input  t_in                        i_in,
    input  logic                       i_queue_full,
    output logic                       o_wr,
    output logic [4*NUMBER_DIGITS-1:0] o_digits,
    output t_job_ctl                   o_ctl
);

    localparam int DW = 4 * NUMBER_DIGITS;

    logic          r_at_line_start;
    logic          r_squeezing;
    logic [DW-1:0] r_count;

    logic          n_at_line_start;
    logic          n_squeezing;
    logic [DW-1:0] n_count;

    logic          accept;
    logic          eff_als, eff_sq;
    logic [DW-1:0] eff_cnt, inc_cnt;
    logic [NUMBER_DIGITS:0] carry;
    logic [7:0]    c;
    logic          is_nl, is_tab, drop, num;

    assign accept = i_push && !i_queue_full;
    assign c      = i_in.data_byte;
    assign is_nl  = (c == CH_NL);
    assign is_tab = (c == CH_TAB);

    assign eff_als = i_in.file_start ? 1'b1 : r_at_line_start;
    assign eff_sq  = i_in.file_start ? 1'b0 : r_squeezing;
    assign eff_cnt = i_in.file_start ? '0 : r_count;

    // BCD increment: a digit steps when all digits below it are nine.
    // All nines is the ceiling and stays put.
    always_comb begin
        carry[0] = 1'b1;
        inc_cnt  = eff_cnt;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            carry[i+1] = carry[i] && (eff_cnt[4*i +: 4] == 4'd9);
            if (carry[i]) begin
                inc_cnt[4*i +: 4] = (eff_cnt[4*i +: 4] == 4'd9) ? 4'd0
                                                                 : eff_cnt[4*i +: 4] + 4'd1;
            end
        end
        if (carry[NUMBER_DIGITS]) begin
            inc_cnt = eff_cnt;
        end
    end

    assign drop = eff_als && i_cfg.squeeze_blank && is_nl && eff_sq;
    assign num  = eff_als && (i_cfg.number_mode != NUM_OFF)
                  && ((i_cfg.number_mode == NUM_ALL) || !is_nl);

    always_comb begin
        n_at_line_start = r_at_line_start;
        n_squeezing     = r_squeezing;
        n_count         = r_count;
        if (accept) begin
            if (drop) begin
                n_at_line_start = 1'b1;
                n_squeezing     = 1'b1;
                n_count         = eff_cnt;
            end else begin
                n_at_line_start = is_nl;
                n_squeezing     = (eff_als && i_cfg.squeeze_blank) ? is_nl : eff_sq;
                n_count         = num ? inc_cnt : eff_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_squeezing     <= 1'b0;
            r_count         <= '0;
        end else begin
            r_at_line_start <= n_at_line_start;
            r_squeezing     <= n_squeezing;
            r_count         <= n_count;
        end
    end

    // Tail bytes: the escaped or raw form of the byte itself.
    always_comb begin
        o_ctl.has_num   = num;
        o_ctl.tail_last = 2'd0;
        o_ctl.tail      = '{default: 8'd0};
        o_ctl.tail[0]   = c;
        if (!is_nl && !is_tab && i_cfg.show_nonprinting) begin
            if (c < CH_SPACE) begin
                o_ctl.tail_last = 2'd1;
                o_ctl.tail[0]   = CH_CARET;
                o_ctl.tail[1]   = c + CTRL_OFFSET;
            end else if (c == CH_DEL) begin
                o_ctl.tail_last = 2'd1;
                o_ctl.tail[0]   = CH_CARET;
                o_ctl.tail[1]   = CH_QUEST;
            end else if (c >= CH_META_LO && c <= CH_META_HI) begin
                o_ctl.tail_last = 2'd3;
                o_ctl.tail[0]   = CH_UPPER_M;
                o_ctl.tail[1]   = CH_MINUS;
                o_ctl.tail[2]   = CH_CARET;
                o_ctl.tail[3]   = c - CTRL_OFFSET;
            end
        end else if (i_cfg.show_ends && is_nl) begin
            o_ctl.tail_last = 2'd1;
            o_ctl.tail[0]   = CH_DOLLAR;
            o_ctl.tail[1]   = c;
        end else if (i_cfg.show_tabs && is_tab) begin
            o_ctl.tail_last = 2'd1;
            o_ctl.tail[0]   = CH_CARET;
            o_ctl.tail[1]   = CH_UPPER_I;
        end
    end

    assign o_wr     = accept && !drop;
    assign o_digits = n_count;

endmodule

// File: hdl/tlnef_back.sv
// ----------------------------------------------------------------------------
// tlnef_back: result emitter
// Walks one job record at a time, one output byte per cycle unless stalled by
// pop: padded line number and tab if present, then tail bytes, to output reg.
// ----------------------------------------------------------------------------
module tlnef_back
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  logic [4*NUMBER_DIGITS-1:0] i_digits,
    input  t_job_ctl                   i_ctl,
    output logic                       o_job_done,
    input  logic                       i_pop,
    output logic                       o_empty,
    output t_out                       o_out
);

    localparam int PW = $clog2(NUMBER_DIGITS + 5);
    localparam logic [PW-1:0] POS_TAB  = PW'(NUMBER_DIGITS);
    localparam logic [PW-1:0] POS_TAIL = PW'(NUMBER_DIGITS + 1);

    logic          r_busy;
    logic [PW-1:0] r_pos;
    logic          r_lead;
    logic          r_out_valid;
    t_out          r_out;

    logic          fire;
    logic [PW-1:0] pos_cur, tail_pos;
    logic          lead_cur, is_space, last;
    logic [3:0]    dsel;
    logic [7:0]    byte_cur;

    assign fire     = i_job_valid && (!r_out_valid || i_pop);
    assign pos_cur  = r_busy ? r_pos : (i_ctl.has_num ? '0 : POS_TAIL);
    assign lead_cur = r_busy ? r_lead : 1'b1;
    assign tail_pos = pos_cur - POS_TAIL;

    always_comb begin
        dsel = 4'd0;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (pos_cur == PW'(NUMBER_DIGITS - 1 - i)) begin
                dsel = i_digits[4*i +: 4];
            end
        end
    end

    // Leading zeros print as spaces, except the units digit.
    assign is_space = lead_cur && (dsel == 4'd0) && (pos_cur != PW'(NUMBER_DIGITS - 1));
    assign last     = (pos_cur >= POS_TAIL) && (tail_pos[1:0] == i_ctl.tail_last);

    always_comb begin
        if (pos_cur < POS_TAB) begin
            byte_cur = is_space ? CH_SPACE : (CH_ZERO | {4'd0, dsel});
        end else if (pos_cur == POS_TAB) begin
            byte_cur = CH_TAB;
        end else begin
            byte_cur = i_ctl.tail[tail_pos[1:0]];
        end
    end

    assign o_job_done = fire && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_lead      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_pos  <= pos_cur + 1'b1;
                    r_lead <= lead_cur && is_space;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.out_byte    <= byte_cur;
            r_out.last_of_run <= last;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line number / escape text filter
// Streams text bytes into the filter through its push/full side, drains the
// filtered bytes through its empty/pop side, and checks every result item
// against a cycle-free software filter kept inside the bench. Both sides
// idle at random, and the run walks through several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import tlnef_pkg::*;

    // The filter runs with its default digit count, so line numbers are six
    // places wide and the largest one is 999999.
    localparam int NUM_DIGITS = DEF_NUMBER_DIGITS;
    localparam int LINE_LIMIT = 10 ** NUM_DIGITS - 1;

    // Numbering modes beyond the two that the package names.
    localparam logic [1:0] NUM_NONBLANK = 2'd2;
    localparam logic [1:0] NUM_UNUSED   = 2'd3;

    // Quiet cycles after the last result before a register write or the end:
    // a squeezed blank line is dropped in the classifier and gives no result.
    localparam int DRAIN_CYCLES = 16;
    // Cycles with no accepted item, result or register write before giving up.
    localparam int WATCHDOG_LIMIT = 1000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = CFG_NUMBER_MODE;
    logic [1:0] i_cfg_wdata = 2'd0;
    logic       push = 1'b0;
    logic       full;
    t_in        i_in = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out       o_out;

    text_line_number_escape_filter #(
        .NUMBER_DIGITS(NUM_DIGITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Text waiting to be sent, and the filtered bytes still to come back.
    t_in  text_q[$];
    t_out filtered_bytes_q[$];

    int   sent_total = 0;
    int   accepted_cnt = 0;
    int   err_cnt = 0;

    // The bench's own copy of the registers and of the line state.
    t_cfg cfg_now = '0;
    bit   pred_at_line_start = 1'b1;
    bit   pred_squeezing = 1'b0;
    int   pred_line_no = 0;

    // ------------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------------

    function automatic void emit_byte(input logic [7:0] b);
        t_out r;
        r.out_byte = b;
        r.last_of_run = 1'b0;
        filtered_bytes_q.push_back(r);
    endfunction

    // Appends the filtered bytes that one accepted text item produces.
    function automatic void predict_filtered_bytes(input t_in item);
        logic [7:0] c;
        bit         nl;
        bit         lead;
        int         pow;
        int         d;
        t_out       r;
        c = item.data_byte;
        nl = (c == CH_NL);

        // A new file starts with fresh line state and a zero counter.
        if (item.file_start) begin
            pred_at_line_start = 1'b1;
            pred_squeezing = 1'b0;
            pred_line_no = 0;
        end

        if (pred_at_line_start) begin
            if (cfg_now.squeeze_blank) begin
                if (nl) begin
                    // A second empty line in a run vanishes without a trace,
                    // and the line state stays where it is.
                    if (pred_squeezing)
                        return;
                    pred_squeezing = 1'b1;
                end else begin
                    pred_squeezing = 1'b0;
                end
            end
            // The unused mode value numbers like the non-blank mode.
            if (cfg_now.number_mode != NUM_OFF &&
                (cfg_now.number_mode == NUM_ALL || !nl)) begin
                if (pred_line_no < LINE_LIMIT)
                    pred_line_no++;
                pow = 1;
                for (int i = 1; i < NUM_DIGITS; i++)
                    pow *= 10;
                lead = 1'b1;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    d = (pred_line_no / pow) % 10;
                    if (d != 0 || i == NUM_DIGITS - 1)
                        lead = 1'b0;
                    emit_byte(lead ? CH_SPACE : CH_ZERO + 8'(d));
                    pow /= 10;
                end
                emit_byte(CH_TAB);
            end
        end

        if (!nl && c != CH_TAB && cfg_now.show_nonprinting) begin
            if (c < CH_SPACE) begin
                emit_byte(CH_CARET);
                emit_byte(c + CTRL_OFFSET);
            end else if (c == CH_DEL) begin
                emit_byte(CH_CARET);
                emit_byte(CH_QUEST);
            end else if (c >= CH_META_LO && c <= CH_META_HI) begin
                emit_byte(CH_UPPER_M);
                emit_byte(CH_MINUS);
                emit_byte(CH_CARET);
                emit_byte(c - CTRL_OFFSET);
            end else begin
                emit_byte(c);
            end
        end else if (cfg_now.show_ends && nl) begin
            emit_byte(CH_DOLLAR);
            emit_byte(c);
        end else if (cfg_now.show_tabs && c == CH_TAB) begin
            emit_byte(CH_CARET);
            emit_byte(CH_UPPER_I);
        end else begin
            emit_byte(c);
        end

        pred_at_line_start = nl;
        // Mark the final byte of this item's run.
        r = filtered_bytes_q.pop_back();
        r.last_of_run = 1'b1;
        filtered_bytes_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then long,
    // and none at all while that side is in a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Text content skewed toward printable bytes, with every byte class
    // that the escapes treat differently showing up often.
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(32, 126));
        if (r < 50)
            return CH_TAB;
        if (r < 62)
            return 8'($urandom_range(0, 31));
        if (r < 67)
            return CH_DEL;
        if (r < 77)
            return 8'($urandom_range(128, 159));
        if (r < 90)
            return 8'($urandom_range(160, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_cfg make_cfg(input logic [1:0] mode, input bit squeeze,
                                      input bit ends, input bit tabs, input bit nonprint);
        t_cfg cfg;
        cfg.number_mode = mode;
        cfg.squeeze_blank = squeeze;
        cfg.show_ends = ends;
        cfg.show_tabs = tabs;
        cfg.show_nonprinting = nonprint;
        return cfg;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit fs);
        t_in item;
        item.data_byte = b;
        item.file_start = fs;
        text_q.push_back(item);
        sent_total++;
    endtask

    // Queues whole lines of random content. A line may open a new file, and
    // now and then a stray new-file flag lands mid-line. The blank-heavy form
    // makes a long single file of mostly empty lines to carry the counter
    // through many lines.
    task automatic queue_text(input int n_items, input int file_pct, input bit blank_heavy);
        int made;
        int len;
        bit fresh_file;
        bit fs;
        made = 0;
        while (made < n_items) begin
            if (blank_heavy) begin
                len = ($urandom_range(0, 3) == 0) ? 1 : 0;
            end else begin
                len = $urandom_range(0, 9);
                if ($urandom_range(0, 4) == 0)
                    len = 0;
            end
            fresh_file = ($urandom_range(0, 99) < file_pct);
            for (int j = 0; j <= len && made < n_items; j++) begin
                fs = (j == 0 && fresh_file) ||
                     (!blank_heavy && $urandom_range(0, 99) == 0);
                queue_byte((j == len) ? CH_NL : random_text_byte(), fs);
                made++;
            end
        end
    endtask

    // Registers are written back to back while the filter is idle. The spare
    // upper data bit of the one-bit registers is random; only bit 0 counts.
    task automatic write_cfg(input t_cfg cfg);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_NUMBER_MODE;
        i_cfg_wdata <= cfg.number_mode;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SQUEEZE_BLANK;
        i_cfg_wdata <= {1'($urandom_range(0, 1)), cfg.squeeze_blank};
        @(posedge i_clk);
        i_cfg_idx <= CFG_SHOW_ENDS;
        i_cfg_wdata <= {1'($urandom_range(0, 1)), cfg.show_ends};
        @(posedge i_clk);
        i_cfg_idx <= CFG_SHOW_TABS;
        i_cfg_wdata <= {1'($urandom_range(0, 1)), cfg.show_tabs};
        @(posedge i_clk);
        i_cfg_idx <= CFG_SHOW_NONPRINTING;
        i_cfg_wdata <= {1'($urandom_range(0, 1)), cfg.show_nonprinting};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = cfg;
    endtask

    // Waits until every queued item is taken and every expected byte is back,
    // then lets the pipeline settle.
    task automatic wait_idle();
        while (!(accepted_cnt == sent_total && filtered_bytes_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_cfg cfg, input int n_items);
        write_cfg(cfg);
        queue_text(n_items, 8, 1'b0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers the next item from the text queue, with random
    // gaps between items. The prediction is made when an item is taken.
    // ------------------------------------------------------------------------
    int tx_gap = 0;
    bit tx_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_filtered_bytes(i_in);
                accepted_cnt++;
                if ($urandom_range(0, 49) == 0)
                    tx_calm = !tx_calm;
            end
            // A new item goes out only once the current one is gone, so push
            // is assigned at most once here per edge.
            if (!push || !full) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    push <= 1'b0;
                end else if (text_q.size() > 0) begin
                    i_in <= text_q.pop_front();
                    push <= 1'b1;
                    tx_gap = pick_gap(tx_calm);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: pops with random stalls and checks each result item
    // against the oldest expected byte.
    // ------------------------------------------------------------------------
    int   rx_stall = 0;
    bit   rx_calm = 1'b0;
    t_out want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (filtered_bytes_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("ERROR: result with nothing expected: byte %h last %b",
                                 o_out.out_byte, o_out.last_of_run);
                    err_cnt++;
                end else begin
                    want = filtered_bytes_q.pop_front();
                    if (o_out.out_byte !== want.out_byte ||
                        o_out.last_of_run !== want.last_of_run) begin
                        if (err_cnt < 10)
                            $display("ERROR: expected byte %h last %b, got byte %h last %b",
                                     want.out_byte, want.last_of_run,
                                     o_out.out_byte, o_out.last_of_run);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    rx_calm = !rx_calm;
                rx_stall = pick_gap(rx_calm);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted item, result or register write counts as
    // progress; a long stretch without any means the filter has hung.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with every option on: each escape class, the byte
        // extremes, a squeezed run of empty lines, new files at a line start
        // and in mid-line, and a new file that ends a squeezed run.
        write_cfg(make_cfg(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1));
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(CH_DEL, 1'b0);
        queue_byte(CH_META_LO, 1'b0);
        queue_byte(CH_META_HI, 1'b0);
        queue_byte(8'hA0, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CH_SPACE, 1'b0);
        queue_byte(8'h7E, 1'b0);
        queue_byte(CH_TAB, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_byte(CH_NL, 1'b1);
        queue_byte(CH_NL, 1'b0);
        queue_byte(CH_NL, 1'b1);
        queue_byte(CH_TAB, 1'b0);
        queue_byte(8'h7A, 1'b0);
        queue_byte(8'h79, 1'b1);
        queue_byte(CH_NL, 1'b0);
        wait_idle();

        // Random text under a spread of settings, the extremes among them.
        run_phase(make_cfg(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0), 50);
        run_phase(make_cfg(NUM_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1), 50);
        run_phase(make_cfg(NUM_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b0), 50);
        run_phase(make_cfg(NUM_ALL, 1'b0, 1'b1, 1'b0, 1'b1), 50);
        run_phase(make_cfg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))), 50);

        // One long file of mostly empty lines, every line numbered, so the
        // counter carries into its third digit.
        write_cfg(make_cfg(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b1));
        queue_byte(CH_NL, 1'b1);
        queue_text(150, 0, 1'b1);
        wait_idle();

        if (err_cnt == 0 && filtered_bytes_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
